FILE: rtl/core/assert_macros.svh
// assertion macros shared by the hull core rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked while out of reset
`define CVXH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition that must hold in the cycle after reset
`define CVXH_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("post-reset check failed");

`endif

FILE: rtl/core/cvxh_pkg.sv
// types and constants for the convex hull core
// no dependencies; imported by the front, back and top modules of the core
`default_nettype none

package cvxh_pkg;

    localparam int COORD_W = 12;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int TURN_W  = PROD_W + 1;
    localparam int MAN_W   = COORD_W + 2;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // command passed from the front to the back
    typedef struct packed {
        t_point pt;
        logic   store;
        logic   close;
        logic   drop;
    } t_cmd;

    // one hull vertex ready for transfer
    typedef struct packed {
        t_point pt;
        logic   last;
        logic   drop;
    } t_vertex;

endpackage

`default_nettype wire

FILE: rtl/core/cvxh_fifo.sv
// small first-word-fall-through queue
// depends on nothing; used for the command and result queues
`default_nettype none

module cvxh_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [NW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == NW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cvxh_front.sv
// front end: accepts points and classifies them as store, close or drop
// depends on cvxh_pkg
`default_nettype none

module cvxh_front #(
    parameter int MAX_POINTS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cvxh_pkg::t_coord i_point_x,
    input  cvxh_pkg::t_coord i_point_y,
    input  logic           i_set_end,
    output logic           o_full,
    output cvxh_pkg::t_cmd o_cmd,
    output logic           o_cmd_push,
    input  logic           i_cmd_full
);
    import cvxh_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          room;

    assign o_full     = i_cmd_full;
    assign o_cmd_push = i_push && !i_cmd_full;
    assign room       = (r_count != CW'(MAX_POINTS));

    // command built from the incoming point
    always_comb begin
        o_cmd.pt.x  = i_point_x;
        o_cmd.pt.y  = i_point_y;
        o_cmd.store = room;
        o_cmd.close = i_set_end;
        o_cmd.drop  = r_ovf || !room;
    end

    // occupancy of the current set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (o_cmd_push) begin
            if (i_set_end) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else if (room) begin
                r_count <= r_count + 1'b1;
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/cvxh_back.sv
// back end: point store, angular insertion sort, graham scan, vertex output
// depends on cvxh_pkg
`default_nettype none

module cvxh_back #(
    parameter int MAX_POINTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cvxh_pkg::t_cmd    i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    output cvxh_pkg::t_vertex o_res,
    output logic              o_res_push,
    input  logic              i_res_full
);
    import cvxh_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_START    = 5'd1;
    localparam logic [4:0] S_SORT_RDV = 5'd2;
    localparam logic [4:0] S_SORT_V   = 5'd3;
    localparam logic [4:0] S_SORT_RDP = 5'd4;
    localparam logic [4:0] S_SORT_MUL = 5'd5;
    localparam logic [4:0] S_SORT_CMP = 5'd6;
    localparam logic [4:0] S_SORT_PUT = 5'd7;
    localparam logic [4:0] S_SCAN_I0  = 5'd8;
    localparam logic [4:0] S_SCAN_I1  = 5'd9;
    localparam logic [4:0] S_SCAN_RD  = 5'd10;
    localparam logic [4:0] S_SCAN_LD  = 5'd11;
    localparam logic [4:0] S_SCAN_MUL = 5'd12;
    localparam logic [4:0] S_SCAN_CMP = 5'd13;
    localparam logic [4:0] S_SCAN_POP = 5'd14;
    localparam logic [4:0] S_OUT_RD   = 5'd15;
    localparam logic [4:0] S_OUT_WR   = 5'd16;

    // memories
    t_point r_arr [MAX_POINTS];
    t_point r_stk [MAX_POINTS];
    t_point r_arr_rd;
    t_point r_stk_rd;
    logic          arr_we;
    logic [AW-1:0] arr_wa;
    t_point        arr_wd;
    logic [AW-1:0] arr_ra;
    logic          stk_we;
    logic [AW-1:0] stk_wa;
    t_point        stk_wd;
    logic [AW-1:0] stk_ra;

    // control and data registers
    logic [4:0]    r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_depth, n_depth;
    logic          r_echo, n_echo;
    logic          r_drop, n_drop;
    logic [AW-1:0] r_pidx, n_pidx;
    t_point r_piv, n_piv;
    t_point r_first, n_first;
    t_point r_v, n_v;
    t_point r_w, n_w;
    t_point r_cur, n_cur;
    t_point r_top, n_top;
    t_point r_sec, n_sec;

    // cross product unit
    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic signed [PROD_W-1:0] n_p1, n_p2;
    logic signed [DIFF_W-1:0] dxa, dya, dxb, dyb;
    logic signed [TURN_W-1:0] turn;
    t_point                   op_o, op_a, op_b;
    logic                     scan_sel;
    logic                     less;
    logic [MAN_W-1:0]         man_v, man_w;

    function automatic logic [MAN_W-1:0] manh(input t_point p, input t_point o);
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        ax = (p.x >= o.x) ? p.x - o.x : o.x - p.x;
        ay = (p.y >= o.y) ? p.y - o.y : o.y - p.y;
        return MAN_W'(ax) + MAN_W'(ay);
    endfunction

    // operand select and products
    always_comb begin
        scan_sel = (r_state == S_SCAN_MUL);
        op_o = scan_sel ? r_sec : r_piv;
        op_a = scan_sel ? r_top : r_v;
        op_b = scan_sel ? r_cur : r_arr_rd;
        dxa  = $signed({1'b0, op_a.x}) - $signed({1'b0, op_o.x});
        dya  = $signed({1'b0, op_a.y}) - $signed({1'b0, op_o.y});
        dxb  = $signed({1'b0, op_b.x}) - $signed({1'b0, op_o.x});
        dyb  = $signed({1'b0, op_b.y}) - $signed({1'b0, op_o.y});
        n_p1 = dxa * dyb;
        n_p2 = dya * dxb;
    end

    // turn sign and angular order
    always_comb begin
        turn  = TURN_W'(r_p1) - TURN_W'(r_p2);
        man_v = manh(r_v, r_piv);
        man_w = manh(r_w, r_piv);
        less  = (turn == '0) ? (man_v < man_w) : (turn > 0);
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_depth = r_depth;
        n_echo  = r_echo;
        n_drop  = r_drop;
        n_pidx  = r_pidx;
        n_piv   = r_piv;
        n_first = r_first;
        n_v     = r_v;
        n_w     = r_w;
        n_cur   = r_cur;
        n_top   = r_top;
        n_sec   = r_sec;
        arr_we  = 1'b0;
        arr_wa  = r_j[AW-1:0];
        arr_wd  = r_v;
        arr_ra  = r_k[AW-1:0];
        stk_we  = 1'b0;
        stk_wa  = r_depth[AW-1:0];
        stk_wd  = r_cur;
        stk_ra  = r_k[AW-1:0];
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res.pt   = r_echo ? r_arr_rd : r_stk_rd;
        o_res.last = (r_k + 1'b1 == r_depth);
        o_res.drop = r_drop;

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.store) begin
                        arr_we = 1'b1;
                        arr_wa = r_n[AW-1:0];
                        arr_wd = i_cmd.pt;
                        n_n    = r_n + 1'b1;
                        if (r_n == '0) begin
                            n_first = i_cmd.pt;
                        end
                        if (r_n == '0 || i_cmd.pt.y < r_piv.y ||
                            (i_cmd.pt.y == r_piv.y && i_cmd.pt.x < r_piv.x)) begin
                            n_piv  = i_cmd.pt;
                            n_pidx = r_n[AW-1:0];
                        end
                    end
                    if (i_cmd.close) begin
                        n_drop  = i_cmd.drop;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_k = '0;
                if (r_n < CW'(3)) begin
                    n_echo  = 1'b1;
                    n_depth = r_n;
                    n_state = S_OUT_RD;
                end else begin
                    // first point moves into the pivot's slot
                    n_echo  = 1'b0;
                    arr_we  = 1'b1;
                    arr_wa  = r_pidx;
                    arr_wd  = r_first;
                    n_i     = CW'(2);
                    n_state = S_SORT_RDV;
                end
            end
            S_SORT_RDV: begin
                arr_ra = r_i[AW-1:0];
                n_state = (r_i == r_n) ? S_SCAN_I0 : S_SORT_V;
            end
            S_SORT_V: begin
                n_v     = r_arr_rd;
                n_j     = r_i;
                n_state = S_SORT_RDP;
            end
            S_SORT_RDP: begin
                arr_ra  = AW'(r_j - 1'b1);
                n_state = S_SORT_MUL;
            end
            S_SORT_MUL: begin
                n_w     = r_arr_rd;
                n_state = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                arr_we = 1'b1;
                if (less) begin
                    // shift the neighbour up one place
                    arr_wd  = r_w;
                    n_j     = r_j - 1'b1;
                    n_state = (r_j - 1'b1 > CW'(1)) ? S_SORT_RDP : S_SORT_PUT;
                end else begin
                    arr_wd  = r_v;
                    n_i     = r_i + 1'b1;
                    n_state = S_SORT_RDV;
                end
            end
            S_SORT_PUT: begin
                arr_we  = 1'b1;
                arr_wd  = r_v;
                n_i     = r_i + 1'b1;
                n_state = S_SORT_RDV;
            end
            S_SCAN_I0: begin
                arr_ra  = AW'(1);
                stk_we  = 1'b1;
                stk_wa  = '0;
                stk_wd  = r_piv;
                n_sec   = r_piv;
                n_state = S_SCAN_I1;
            end
            S_SCAN_I1: begin
                stk_we  = 1'b1;
                stk_wa  = AW'(1);
                stk_wd  = r_arr_rd;
                n_top   = r_arr_rd;
                n_depth = CW'(2);
                n_i     = CW'(2);
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                arr_ra = r_i[AW-1:0];
                if (r_i == r_n) begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_SCAN_LD;
                end
            end
            S_SCAN_LD: begin
                n_cur   = r_arr_rd;
                n_state = S_SCAN_MUL;
            end
            S_SCAN_MUL: begin
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                stk_ra = AW'(r_depth - CW'(3));
                if (turn <= 0 && r_depth > CW'(1)) begin
                    if (r_depth > CW'(2)) begin
                        // pop, then refetch the entry below the new top
                        n_top   = r_sec;
                        n_depth = r_depth - 1'b1;
                        n_state = S_SCAN_POP;
                    end else begin
                        // pop down to the pivot and push at once
                        stk_we  = 1'b1;
                        stk_wa  = AW'(1);
                        n_top   = r_cur;
                        n_depth = CW'(2);
                        n_i     = r_i + 1'b1;
                        n_state = S_SCAN_RD;
                    end
                end else begin
                    stk_we  = 1'b1;
                    n_sec   = r_top;
                    n_top   = r_cur;
                    n_depth = r_depth + 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_POP: begin
                n_sec   = r_stk_rd;
                n_state = S_SCAN_MUL;
            end
            S_OUT_RD: begin
                n_state = S_OUT_WR;
            end
            S_OUT_WR: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_k        = r_k + 1'b1;
                    if (r_k + 1'b1 == r_depth) begin
                        n_n     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // point and stack memories with registered reads
    always_ff @(posedge i_clk) begin
        if (arr_we) begin
            r_arr[arr_wa] <= arr_wd;
        end
        r_arr_rd <= r_arr[arr_ra];
        if (stk_we) begin
            r_stk[stk_wa] <= stk_wd;
        end
        r_stk_rd <= r_stk[stk_ra];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_depth <= '0;
            r_echo  <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_depth <= n_depth;
            r_echo  <= n_echo;
            r_drop  <= n_drop;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx  <= n_pidx;
        r_piv   <= n_piv;
        r_first <= n_first;
        r_v     <= n_v;
        r_w     <= n_w;
        r_cur   <= n_cur;
        r_top   <= n_top;
        r_sec   <= n_sec;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
    end

endmodule

`default_nettype wire

FILE: rtl/core/convex_hull_graham_scan_core.sv
// convex hull core: loads a point set, emits its hull vertices in scan order
// a point is taken on push while full is low; i_set_end closes the set
// sort: RDV, V per point; RDP, MUL, CMP per compare step; PUT when it reaches the front
// scan: RD, LD, MUL, CMP per point; POP, MUL, CMP per pop; output: RD, WR per vertex
// reset is synchronous, active low; queues empty, the set is cleared
`default_nettype none

module convex_hull_graham_scan_core #(
    parameter int MAX_POINTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [11:0]          i_point_x,
    input  logic [11:0]          i_point_y,
    input  logic                 i_set_end,
    output logic                 empty,
    input  logic                 pop,
    output logic [11:0]          o_vertex_x,
    output logic [11:0]          o_vertex_y,
    output logic                 o_final_vertex,
    output logic                 o_points_dropped
);
    import cvxh_pkg::*;

    localparam int QDEPTH = 4;

    t_cmd    cmd_in, cmd_out;
    t_vertex res_in, res_out;
    logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic    res_push, res_full;

    // front end
    cvxh_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_set_end  (i_set_end),
        .o_full     (full),
        .o_cmd      (cmd_in),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full)
    );

    // command queue between front and back
    cvxh_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(QDEPTH)) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    // hull engine
    cvxh_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_res       (res_in),
        .o_res_push  (res_push),
        .i_res_full  (res_full)
    );

    // result queue
    cvxh_fifo #(.WIDTH($bits(t_vertex)), .DEPTH(QDEPTH)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_vertex_x       = res_out.pt.x;
    assign o_vertex_y       = res_out.pt.y;
    assign o_final_vertex   = res_out.last;
    assign o_points_dropped = res_out.drop;

    // checks
`include "assert_macros.svh"

    `CVXH_ASSERT_IMP(a_res_no_overrun, i_clk, i_rst_n, res_push, !res_full)
    `CVXH_ASSERT_IMP(a_cmd_pop_valid, i_clk, i_rst_n, cmd_pop, !cmd_empty)
    `CVXH_ASSERT_RST(a_reset_clear, i_clk, i_rst_n, empty && !full)

endmodule

`default_nettype wire
